// File: rtl/pwu_pkg.sv
// ----------------------------------------------------------------------------
// pwu_pkg
// Op codes, action codes and defaults shared by the page watchpoint unit.
// ----------------------------------------------------------------------------
package pwu_pkg;

    localparam int DEF_WATCH_SLOTS = 8;
    localparam int DEF_LOG_DEPTH   = 64;
    localparam int READ_MAX        = 64;
    localparam int PAGE_SHIFT      = 12;

    typedef enum logic [2:0] {
        OP_SET       = 3'd0,
        OP_CLEAR     = 3'd1,
        OP_CLEAR_ALL = 3'd2,
        OP_FAULT     = 3'd3,
        OP_TRAP      = 3'd4,
        OP_READ_LOG  = 3'd5
    } op_t;

    localparam logic [1:0] PAGE_NONE        = 2'd0;
    localparam logic [1:0] PAGE_NOT_PRESENT = 2'd1;
    localparam logic [1:0] PAGE_PRESENT     = 2'd2;

    localparam logic [1:0] TRAP_NONE  = 2'd0;
    localparam logic [1:0] TRAP_SET   = 2'd1;
    localparam logic [1:0] TRAP_CLEAR = 2'd2;

    localparam logic [2:0] SIZE_MIN = 3'd1;
    localparam logic [2:0] SIZE_MAX = 3'd4;

endpackage

// File: rtl/page_watchpoint_unit.sv
// ----------------------------------------------------------------------------
// page_watchpoint_unit
// Page-granular watchpoint table with a ring log of watch hits.
// ----------------------------------------------------------------------------
//  channel   dir  handshake          payload
//  s_*       in   s_valid / s_ready  op, addr, size, tick, segment, pointer, limit
//  m_*       out  m_valid / m_ready  accepted, actions, log entry, hit total, last
//
//  Slot scans walk the slot RAM one entry per cycle unless the output stalls:
//  set, clear, clear all and page fault scan up to every slot, a trap one slot.
//  A log read fetches each entry via the ring RAM read port and a wait state.
//  One op is processed at a time; the next op is taken on return to idle,
//  even while the final result still sits in the output register.
//  A stalled output register holds the scan or readout in place.
//  Reset clears valid marks, pending, ring index and hit count; no RAM sweep.
// ----------------------------------------------------------------------------
module page_watchpoint_unit
    import pwu_pkg::*;
#(
    parameter int WATCH_SLOTS = DEF_WATCH_SLOTS,
    parameter int LOG_DEPTH   = DEF_LOG_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_op,
    input  logic [31:0] s_addr,
    input  logic [2:0]  s_size,
    input  logic [31:0] s_tick,
    input  logic [15:0] s_code_segment,
    input  logic [15:0] s_instr_pointer,
    input  logic [6:0]  s_read_limit,

    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_accepted,
    output logic [1:0]  m_page_action,
    output logic [19:0] m_page_number,
    output logic [1:0]  m_trap_action,
    output logic [31:0] m_log_tick,
    output logic [31:0] m_log_addr,
    output logic [15:0] m_log_segment,
    output logic [15:0] m_log_pointer,
    output logic [31:0] m_hit_total,
    output logic        m_last
);

    localparam int SW       = (WATCH_SLOTS > 1) ? $clog2(WATCH_SLOTS) : 1;
    localparam int LW       = $clog2(LOG_DEPTH);
    localparam int READ_CAP = (LOG_DEPTH < READ_MAX) ? LOG_DEPTH : READ_MAX;
    localparam int SLOT_W   = 35;
    localparam int RING_W   = 96;

    typedef enum logic [4:0] {
        ST_IDLE      = 5'b00001,
        ST_SCAN      = 5'b00010,
        ST_RING_WAIT = 5'b00100,
        ST_RING_OUT  = 5'b01000,
        ST_MISS      = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // control
    logic [SW-1:0]          ptr_reg, ptr_next;
    logic [SW-1:0]          end_reg, end_next;
    logic [SW-1:0]          pidx_reg, pidx_next;
    logic                   pvld_reg, pvld_next;
    logic                   issued_reg, issued_next;
    logic [WATCH_SLOTS-1:0] valid_reg, valid_next;
    logic                   pend_vld_reg, pend_vld_next;
    logic [SW-1:0]          pend_slot_reg, pend_slot_next;
    logic [LW-1:0]          ring_wr_reg, ring_wr_next;
    logic [31:0]            hit_cnt_reg, hit_cnt_next;
    logic [LW-1:0]          rptr_reg, rptr_next;
    logic [6:0]             rcnt_reg, rcnt_next;
    logic                   out_vld_reg;

    // latched op
    op_t         op_reg;
    logic [31:0] addr_reg;
    logic [2:0]  size_reg;
    logic [31:0] tick_reg;
    logic [15:0] seg_reg;
    logic [15:0] ip_reg;

    // output register
    logic        acc_reg;
    logic [1:0]  pact_reg;
    logic [19:0] page_reg;
    logic [1:0]  tact_reg;
    logic [31:0] ltick_reg;
    logic [31:0] laddr_reg;
    logic [15:0] lseg_reg;
    logic [15:0] lip_reg;
    logic [31:0] hit_reg;
    logic        last_reg;

    logic        o_acc;
    logic [1:0]  o_pact;
    logic [19:0] o_page;
    logic [1:0]  o_tact;
    logic [31:0] o_hit;
    logic        o_last;
    logic        o_log;
    logic        out_load;

    // memories
    logic [SLOT_W-1:0] slot_mem [WATCH_SLOTS];
    logic [SLOT_W-1:0] slot_q;
    logic [SW-1:0]     slot_ra;
    logic              slot_we;
    logic [RING_W-1:0] ring_mem [LOG_DEPTH];
    logic [RING_W-1:0] ring_q;
    logic              ring_we;

    logic              accept;
    logic              can_load;
    logic              hit;
    logic              ca_last;
    logic [WATCH_SLOTS-1:0] sel;
    logic [31:0]       slot_addr;
    logic [6:0]        cap;
    logic [6:0]        cnt;
    logic [LW-1:0]     rstart;
    logic [2:0]        size_clamp;

    assign accept   = s_valid && s_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign can_load = !out_vld_reg || m_ready;
    assign slot_addr = slot_q[31:0];

    always_comb begin
        cap = (s_read_limit > 7'(READ_CAP)) ? 7'(READ_CAP) : s_read_limit;
        cnt = (hit_cnt_reg < {25'b0, cap}) ? hit_cnt_reg[6:0] : cap;
        rstart = (hit_cnt_reg > 32'(LOG_DEPTH)) ? ring_wr_reg : '0;
        if (s_size < SIZE_MIN) begin
            size_clamp = SIZE_MIN;
        end else if (s_size > SIZE_MAX) begin
            size_clamp = SIZE_MAX;
        end else begin
            size_clamp = s_size;
        end
        sel = '0;
        sel[pidx_reg] = 1'b1;
        ca_last = ~|(valid_reg & ~sel);
    end

    always_comb begin
        state_next     = state_reg;
        ptr_next       = ptr_reg;
        end_next       = end_reg;
        pidx_next      = pidx_reg;
        pvld_next      = pvld_reg;
        issued_next    = issued_reg;
        valid_next     = valid_reg;
        pend_vld_next  = pend_vld_reg;
        pend_slot_next = pend_slot_reg;
        ring_wr_next   = ring_wr_reg;
        hit_cnt_next   = hit_cnt_reg;
        rptr_next      = rptr_reg;
        rcnt_next      = rcnt_reg;
        slot_ra        = ptr_reg;
        slot_we        = 1'b0;
        ring_we        = 1'b0;
        hit            = 1'b0;
        out_load       = 1'b0;
        o_acc          = 1'b0;
        o_pact         = PAGE_NONE;
        o_page         = '0;
        o_tact         = TRAP_NONE;
        o_hit          = hit_cnt_reg;
        o_last         = 1'b1;
        o_log          = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    ptr_next    = '0;
                    end_next    = SW'(WATCH_SLOTS - 1);
                    pvld_next   = 1'b0;
                    issued_next = 1'b0;
                    case (op_t'(s_op))
                        OP_SET, OP_CLEAR, OP_FAULT: begin
                            state_next = ST_SCAN;
                        end
                        OP_CLEAR_ALL: begin
                            pend_vld_next = 1'b0;
                            state_next    = ST_SCAN;
                        end
                        OP_TRAP: begin
                            pend_vld_next = 1'b0;
                            ptr_next      = pend_slot_reg;
                            end_next      = pend_slot_reg;
                            state_next    = pend_vld_reg ? ST_SCAN : ST_MISS;
                        end
                        OP_READ_LOG: begin
                            rcnt_next  = cnt;
                            rptr_next  = rstart;
                            state_next = (cnt == 7'd0) ? ST_MISS : ST_RING_WAIT;
                        end
                        default: begin
                            state_next = ST_MISS;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (!can_load) begin
                    slot_ra = pidx_reg;
                end else begin
                    if (!issued_reg) begin
                        pvld_next = 1'b1;
                        pidx_next = ptr_reg;
                        if (ptr_reg == end_reg) begin
                            issued_next = 1'b1;
                        end else begin
                            ptr_next = ptr_reg + 1'b1;
                        end
                    end else begin
                        pvld_next = 1'b0;
                    end
                    if (pvld_reg) begin
                        case (op_reg)
                            OP_SET: begin
                                hit    = !valid_reg[pidx_reg];
                                o_pact = PAGE_NOT_PRESENT;
                                o_page = addr_reg[31:PAGE_SHIFT];
                                if (hit) begin
                                    slot_we               = 1'b1;
                                    valid_next[pidx_reg]  = 1'b1;
                                end
                            end
                            OP_CLEAR: begin
                                hit    = valid_reg[pidx_reg] && (slot_addr == addr_reg);
                                o_pact = PAGE_PRESENT;
                                o_page = slot_addr[31:PAGE_SHIFT];
                                if (hit) begin
                                    valid_next[pidx_reg] = 1'b0;
                                end
                            end
                            OP_CLEAR_ALL: begin
                                hit    = valid_reg[pidx_reg];
                                o_pact = PAGE_PRESENT;
                                o_page = slot_addr[31:PAGE_SHIFT];
                                o_last = ca_last;
                                if (hit) begin
                                    valid_next[pidx_reg] = 1'b0;
                                end
                            end
                            OP_FAULT: begin
                                hit    = valid_reg[pidx_reg] &&
                                         (slot_addr[31:PAGE_SHIFT] == addr_reg[31:PAGE_SHIFT]);
                                o_pact = PAGE_PRESENT;
                                o_page = addr_reg[31:PAGE_SHIFT];
                                o_tact = TRAP_SET;
                                o_hit  = hit_cnt_reg + 32'd1;
                                if (hit) begin
                                    ring_we        = 1'b1;
                                    ring_wr_next   = (ring_wr_reg == LW'(LOG_DEPTH - 1)) ?
                                                     '0 : ring_wr_reg + 1'b1;
                                    hit_cnt_next   = hit_cnt_reg + 32'd1;
                                    pend_vld_next  = 1'b1;
                                    pend_slot_next = pidx_reg;
                                end
                            end
                            OP_TRAP: begin
                                hit    = valid_reg[pidx_reg];
                                o_pact = PAGE_NOT_PRESENT;
                                o_page = slot_addr[31:PAGE_SHIFT];
                                o_tact = TRAP_CLEAR;
                            end
                            default: begin
                                hit = 1'b0;
                            end
                        endcase
                        if (hit) begin
                            out_load = 1'b1;
                            o_acc    = 1'b1;
                            if (o_last) begin
                                state_next = ST_IDLE;
                                pvld_next  = 1'b0;
                            end
                        end else if (pidx_reg == end_reg) begin
                            out_load   = 1'b1;
                            o_pact     = PAGE_NONE;
                            o_page     = '0;
                            o_tact     = TRAP_NONE;
                            o_hit      = hit_cnt_reg;
                            o_last     = 1'b1;
                            state_next = ST_IDLE;
                            pvld_next  = 1'b0;
                        end
                    end
                end
            end
            ST_RING_WAIT: begin
                state_next = ST_RING_OUT;
            end
            ST_RING_OUT: begin
                if (can_load) begin
                    out_load   = 1'b1;
                    o_acc      = 1'b1;
                    o_log      = 1'b1;
                    o_last     = (rcnt_reg == 7'd1);
                    rcnt_next  = rcnt_reg - 7'd1;
                    rptr_next  = (rptr_reg == LW'(LOG_DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
                    state_next = (rcnt_reg == 7'd1) ? ST_IDLE : ST_RING_WAIT;
                end
            end
            ST_MISS: begin
                if (can_load) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            ptr_reg       <= '0;
            end_reg       <= '0;
            pidx_reg      <= '0;
            pvld_reg      <= 1'b0;
            issued_reg    <= 1'b0;
            valid_reg     <= '0;
            pend_vld_reg  <= 1'b0;
            pend_slot_reg <= '0;
            ring_wr_reg   <= '0;
            hit_cnt_reg   <= '0;
            rptr_reg      <= '0;
            rcnt_reg      <= '0;
            out_vld_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            end_reg       <= end_next;
            pidx_reg      <= pidx_next;
            pvld_reg      <= pvld_next;
            issued_reg    <= issued_next;
            valid_reg     <= valid_next;
            pend_vld_reg  <= pend_vld_next;
            pend_slot_reg <= pend_slot_next;
            ring_wr_reg   <= ring_wr_next;
            hit_cnt_reg   <= hit_cnt_next;
            rptr_reg      <= rptr_next;
            rcnt_reg      <= rcnt_next;
            if (out_load) begin
                out_vld_reg <= 1'b1;
            end else if (m_ready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg   <= op_t'(s_op);
            addr_reg <= s_addr;
            size_reg <= size_clamp;
            tick_reg <= s_tick;
            seg_reg  <= s_code_segment;
            ip_reg   <= s_instr_pointer;
        end
        if (out_load) begin
            acc_reg   <= o_acc;
            pact_reg  <= o_pact;
            page_reg  <= o_page;
            tact_reg  <= o_tact;
            hit_reg   <= o_hit;
            last_reg  <= o_last;
            ltick_reg <= o_log ? ring_q[95:64] : 32'd0;
            laddr_reg <= o_log ? ring_q[63:32] : 32'd0;
            lseg_reg  <= o_log ? ring_q[31:16] : 16'd0;
            lip_reg   <= o_log ? ring_q[15:0]  : 16'd0;
        end
    end

    // slot RAM: {size, address}
    always_ff @(posedge aclk) begin
        if (slot_we) begin
            slot_mem[pidx_reg] <= {size_reg, addr_reg};
        end
        slot_q <= slot_mem[slot_ra];
    end

    // hit log RAM: {tick, address, segment, pointer}
    always_ff @(posedge aclk) begin
        if (ring_we) begin
            ring_mem[ring_wr_reg] <= {tick_reg, addr_reg, seg_reg, ip_reg};
        end
        ring_q <= ring_mem[rptr_reg];
    end

    assign m_valid       = out_vld_reg;
    assign m_accepted    = acc_reg;
    assign m_page_action = pact_reg;
    assign m_page_number = page_reg;
    assign m_trap_action = tact_reg;
    assign m_log_tick    = ltick_reg;
    assign m_log_addr    = laddr_reg;
    assign m_log_segment = lseg_reg;
    assign m_log_pointer = lip_reg;
    assign m_hit_total   = hit_reg;
    assign m_last        = last_reg;

    // ring index and hit count move together
    a_ring_cnt_lockstep: assert property (@(posedge aclk) disable iff (!aresetn)
        (ring_wr_reg != $past(ring_wr_reg)) == (hit_cnt_reg != $past(hit_cnt_reg)))
        else $error("ring index and hit count out of step");

    // hit count only moves on a page fault scan
    a_hit_from_fault: assert property (@(posedge aclk) disable iff (!aresetn)
        (hit_cnt_reg != $past(hit_cnt_reg)) |->
        ($past(state_reg) == ST_SCAN && $past(op_reg) == OP_FAULT))
        else $error("hit count changed outside a fault scan");

    // readout never runs with an empty count
    a_ring_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RING_OUT || state_reg == ST_RING_WAIT) |-> (rcnt_reg != 7'd0))
        else $error("log readout with zero remaining");

endmodule

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench for page_watchpoint_unit. A behavioral model of the slot table,
// the pending trap and the hit log ring predicts every result of each op
// transfer; a checker compares each result transfer against the oldest
// prediction. Directed cases cover empty and full tables, shared pages, stale
// and dropped traps and the reserved ops. Randomized watch/fault/trap traffic
// follows, then enough hits to wrap the log ring. Both channels idle at
// random, with one long output stall and drain pauses.
// ----------------------------------------------------------------------------
module tb_top;
    import pwu_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCH_SLOTS    = DEF_WATCH_SLOTS;
    localparam int LOG_DEPTH      = DEF_LOG_DEPTH;
    localparam int POOL_SIZE      = 8;
    localparam int RANDOM_TARGET  = 220;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int STALL_LIMIT    = 4000;
    localparam int TAIL_CYCLES    = 40;

    localparam logic [2:0] OP_RESERVED_A = 3'd6;
    localparam logic [2:0] OP_RESERVED_B = 3'd7;

    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] addr;
        logic [2:0]  size;
        logic [31:0] tick;
        logic [15:0] code_segment;
        logic [15:0] instr_pointer;
        logic [6:0]  read_limit;
    } watch_req_t;

    typedef struct packed {
        logic        accepted;
        logic [1:0]  page_action;
        logic [19:0] page_number;
        logic [1:0]  trap_action;
        logic [31:0] log_tick;
        logic [31:0] log_addr;
        logic [15:0] log_segment;
        logic [15:0] log_pointer;
        logic [31:0] hit_total;
        logic        last;
    } watch_resp_t;

    typedef enum {RX_STREAM, RX_RANDOM, RX_SPARSE} rx_mode_t;

    logic        aclk            = 1'b0;
    logic        aresetn         = 1'b0;
    logic        s_valid         = 1'b0;
    logic        s_ready;
    logic [2:0]  s_op            = '0;
    logic [31:0] s_addr          = '0;
    logic [2:0]  s_size          = '0;
    logic [31:0] s_tick          = '0;
    logic [15:0] s_code_segment  = '0;
    logic [15:0] s_instr_pointer = '0;
    logic [6:0]  s_read_limit    = '0;
    logic        m_valid;
    logic        m_ready         = 1'b0;
    logic        m_accepted;
    logic [1:0]  m_page_action;
    logic [19:0] m_page_number;
    logic [1:0]  m_trap_action;
    logic [31:0] m_log_tick;
    logic [31:0] m_log_addr;
    logic [15:0] m_log_segment;
    logic [15:0] m_log_pointer;
    logic [31:0] m_hit_total;
    logic        m_last;

    // watch table, trap and hit log model
    logic [31:0] watch_addr [WATCH_SLOTS];
    logic [19:0] watch_page [WATCH_SLOTS];
    logic        watch_live [WATCH_SLOTS];
    logic        trap_armed = 1'b0;
    int unsigned trap_slot  = 0;
    logic [31:0] hit_log_tick [LOG_DEPTH];
    logic [31:0] hit_log_addr [LOG_DEPTH];
    logic [15:0] hit_log_seg  [LOG_DEPTH];
    logic [15:0] hit_log_ip   [LOG_DEPTH];
    int unsigned log_head  = 0;
    logic [31:0] hit_count = '0;

    watch_resp_t due_responses[$];
    logic [19:0] page_pool [POOL_SIZE];

    int fail_count   = 0;
    int items_sent   = 0;
    int burst_left   = 0;
    int quiet_cycles = 0;

    logic     rx_hold_req  = 1'b0;
    int       rx_hold_left = 0;
    int       rx_mode_left = 0;
    rx_mode_t rx_mode      = RX_STREAM;

    page_watchpoint_unit DUT (.*);

    always #10 aclk = ~aclk;

    initial begin
        foreach (watch_live[i]) watch_live[i] = 1'b0;
    end

    // ------------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------------
    function automatic watch_resp_t make_resp(input logic acc, input logic [1:0] pact,
                                              input logic [19:0] page,
                                              input logic [1:0] tact);
        watch_resp_t rsp;
        rsp             = '0;
        rsp.accepted    = acc;
        rsp.page_action = pact;
        rsp.page_number = page;
        rsp.trap_action = tact;
        rsp.hit_total   = hit_count;
        return rsp;
    endfunction

    task automatic predict_watch_op(input watch_req_t r);
        watch_resp_t batch[$];
        watch_resp_t rsp;
        logic [19:0] fpage;
        int unsigned count;
        int unsigned first;
        int unsigned idx;
        case (r.op)
            OP_SET: begin
                for (int i = 0; i < WATCH_SLOTS; i++) begin
                    if (!watch_live[i]) begin
                        watch_addr[i] = r.addr;
                        watch_page[i] = r.addr[31:PAGE_SHIFT];
                        watch_live[i] = 1'b1;
                        batch.push_back(make_resp(1'b1, PAGE_NOT_PRESENT, watch_page[i],
                                                  TRAP_NONE));
                        break;
                    end
                end
            end
            OP_CLEAR: begin
                for (int i = 0; i < WATCH_SLOTS; i++) begin
                    if (watch_live[i] && watch_addr[i] == r.addr) begin
                        watch_live[i] = 1'b0;
                        batch.push_back(make_resp(1'b1, PAGE_PRESENT, watch_page[i],
                                                  TRAP_NONE));
                        break;
                    end
                end
            end
            OP_CLEAR_ALL: begin
                for (int i = 0; i < WATCH_SLOTS; i++) begin
                    if (watch_live[i]) begin
                        watch_live[i] = 1'b0;
                        batch.push_back(make_resp(1'b1, PAGE_PRESENT, watch_page[i],
                                                  TRAP_NONE));
                    end
                end
                trap_armed = 1'b0;
            end
            OP_FAULT: begin
                fpage = r.addr[31:PAGE_SHIFT];
                for (int i = 0; i < WATCH_SLOTS; i++) begin
                    if (watch_live[i] && watch_page[i] == fpage) begin
                        hit_log_tick[log_head] = r.tick;
                        hit_log_addr[log_head] = r.addr;
                        hit_log_seg[log_head]  = r.code_segment;
                        hit_log_ip[log_head]   = r.instr_pointer;
                        log_head   = (log_head + 1) % LOG_DEPTH;
                        hit_count  = hit_count + 1;
                        trap_armed = 1'b1;
                        trap_slot  = i;
                        batch.push_back(make_resp(1'b1, PAGE_PRESENT, fpage, TRAP_SET));
                        break;
                    end
                end
            end
            OP_TRAP: begin
                if (trap_armed) begin
                    trap_armed = 1'b0;
                    if (watch_live[trap_slot])
                        batch.push_back(make_resp(1'b1, PAGE_NOT_PRESENT,
                                                  watch_page[trap_slot], TRAP_CLEAR));
                end
            end
            OP_READ_LOG: begin
                count = (hit_count > LOG_DEPTH) ? LOG_DEPTH : hit_count;
                if (count > r.read_limit) count = r.read_limit;
                if (count > READ_MAX) count = READ_MAX;
                first = (hit_count > LOG_DEPTH) ? log_head : 0;
                for (int i = 0; i < count; i++) begin
                    idx = (first + i) % LOG_DEPTH;
                    rsp             = make_resp(1'b1, PAGE_NONE, '0, TRAP_NONE);
                    rsp.log_tick    = hit_log_tick[idx];
                    rsp.log_addr    = hit_log_addr[idx];
                    rsp.log_segment = hit_log_seg[idx];
                    rsp.log_pointer = hit_log_ip[idx];
                    batch.push_back(rsp);
                end
            end
            default: ;
        endcase
        if (batch.size() == 0)
            batch.push_back(make_resp(1'b0, PAGE_NONE, '0, TRAP_NONE));
        batch[batch.size() - 1].last = 1'b1;
        foreach (batch[i]) due_responses.push_back(batch[i]);
    endtask

    // ------------------------------------------------------------------------
    // op channel
    // ------------------------------------------------------------------------
    task automatic send_req(input watch_req_t req);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
        end
        s_valid         <= 1'b1;
        s_op            <= req.op;
        s_addr          <= req.addr;
        s_size          <= req.size;
        s_tick          <= req.tick;
        s_code_segment  <= req.code_segment;
        s_instr_pointer <= req.instr_pointer;
        s_read_limit    <= req.read_limit;
        do @(posedge aclk); while (!s_ready);
        predict_watch_op(req);
        burst_left--;
        items_sent++;
    endtask

    task automatic wait_drained();
        s_valid    <= 1'b0;
        burst_left = 0;
        do @(posedge aclk); while (due_responses.size() != 0);
    endtask

    function automatic watch_req_t fresh_req(input logic [2:0] op);
        watch_req_t req;
        req.op            = op;
        req.addr          = $urandom;
        req.size          = 3'($urandom_range(0, 7));
        req.tick          = $urandom;
        req.code_segment  = 16'($urandom);
        req.instr_pointer = 16'($urandom);
        req.read_limit    = 7'($urandom_range(0, READ_MAX));
        return req;
    endfunction

    task automatic send_set(input logic [31:0] addr, input logic [2:0] size);
        watch_req_t req;
        req      = fresh_req(OP_SET);
        req.addr = addr;
        req.size = size;
        send_req(req);
    endtask

    task automatic send_clear(input logic [31:0] addr);
        watch_req_t req;
        req      = fresh_req(OP_CLEAR);
        req.addr = addr;
        send_req(req);
    endtask

    task automatic send_fault(input logic [31:0] addr);
        watch_req_t req;
        req      = fresh_req(OP_FAULT);
        req.addr = addr;
        send_req(req);
    endtask

    task automatic send_read(input logic [6:0] read_limit);
        watch_req_t req;
        req            = fresh_req(OP_READ_LOG);
        req.read_limit = read_limit;
        send_req(req);
    endtask

    task automatic send_plain(input logic [2:0] op);
        send_req(fresh_req(op));
    endtask

    function automatic int pick_live_slot();
        int live[$];
        for (int i = 0; i < WATCH_SLOTS; i++)
            if (watch_live[i]) live.push_back(i);
        if (live.size() == 0) return -1;
        return live[$urandom_range(0, live.size() - 1)];
    endfunction

    function automatic logic [31:0] pool_addr();
        return {page_pool[$urandom_range(0, POOL_SIZE - 1)], 12'($urandom)};
    endfunction

    // address on a watched page when there is one
    function automatic logic [31:0] watched_page_addr();
        int s;
        s = pick_live_slot();
        if (s < 0) return pool_addr();
        return {watch_page[s], 12'($urandom)};
    endfunction

    // ------------------------------------------------------------------------
    // result channel
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        logic next_ready;
        if (rx_hold_req) begin
            rx_hold_left = RX_HOLD_CYCLES;
            rx_hold_req  = 1'b0;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            next_ready = 1'b0;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode      = rx_mode_t'($urandom_range(0, 2));
                rx_mode_left = $urandom_range(4, 60);
            end
            rx_mode_left--;
            case (rx_mode)
                RX_STREAM: next_ready = 1'b1;
                RX_RANDOM: next_ready = 1'($urandom_range(0, 1));
                default:   next_ready = ($urandom_range(0, 3) == 0);
            endcase
        end
        m_ready <= next_ready;
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        watch_resp_t want;
        if (aresetn && m_valid && m_ready) begin
            if (due_responses.size() == 0) begin
                $error("result transfer with no prediction pending");
                fail_count++;
            end else begin
                want = due_responses.pop_front();
                check_field("accepted",    want.accepted,    m_accepted);
                check_field("page_action", want.page_action, m_page_action);
                check_field("page_number", want.page_number, m_page_number);
                check_field("trap_action", want.trap_action, m_trap_action);
                check_field("log_tick",    want.log_tick,    m_log_tick);
                check_field("log_addr",    want.log_addr,    m_log_addr);
                check_field("log_segment", want.log_segment, m_log_segment);
                check_field("log_pointer", want.log_pointer, m_log_pointer);
                check_field("hit_total",   want.hit_total,   m_hit_total);
                check_field("last",        want.last,        m_last);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $error("no transfer for %0d cycles", STALL_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_idle_table();
        send_read(7'd64);
        send_plain(OP_TRAP);
        send_fault(32'h0BAD_F00D);
        send_clear(32'h0BAD_F00D);
        send_plain(OP_CLEAR_ALL);
        send_plain(OP_RESERVED_A);
        send_plain(OP_RESERVED_B);
    endtask

    task automatic test_fill_table();
        send_set(32'h0000_0000, 3'd0);
        send_set(32'hFFFF_FFFF, 3'd7);
        send_set(32'h1234_5678, 3'd1);
        send_set(32'h1234_5778, 3'd4);
        for (int i = 0; i < WATCH_SLOTS - 4; i++)
            send_set(pool_addr(), 3'($urandom_range(0, 7)));
        send_set(32'h5555_AAAA, 3'd2);
    endtask

    task automatic test_hit_and_rearm();
        send_fault(32'h1234_5FFC);
        send_plain(OP_TRAP);
        // page still watched by the neighbor slot, restored anyway
        send_clear(32'h1234_5678);
        send_fault(32'h1234_5000);
        send_clear(32'h1234_5778);
        send_plain(OP_TRAP);
        send_fault(32'hFFFF_F123);
        send_read(7'd0);
        send_read(7'd64);
        send_plain(OP_CLEAR_ALL);
        send_plain(OP_TRAP);
    endtask

    task automatic test_output_backpressure();
        rx_hold_req = 1'b1;
        repeat (3) send_set(pool_addr(), 3'($urandom_range(0, 7)));
        repeat (3) begin
            send_fault(watched_page_addr());
            send_plain(OP_TRAP);
        end
        send_read(7'd64);
        send_plain(OP_CLEAR_ALL);
        send_read(7'd64);
        repeat (3) send_set(pool_addr(), 3'($urandom_range(0, 7)));
        wait_drained();
    endtask

    task automatic test_random_mix();
        int pick;
        int s;
        while (items_sent < RANDOM_TARGET) begin
            pick = $urandom_range(0, 99);
            if (pick < 24) begin
                send_set(pool_addr(), 3'($urandom_range(0, 7)));
            end else if (pick < 50) begin
                send_fault(($urandom_range(0, 4) != 0) ? watched_page_addr() : pool_addr());
                if ($urandom_range(0, 99) < 85) send_plain(OP_TRAP);
            end else if (pick < 62) begin
                s = pick_live_slot();
                if (s >= 0 && $urandom_range(0, 4) != 0)
                    send_clear(watch_addr[s]);
                else
                    send_clear(($urandom_range(0, 1) == 0) ? pool_addr() : $urandom);
            end else if (pick < 66) begin
                send_plain(OP_CLEAR_ALL);
            end else if (pick < 76) begin
                send_read(($urandom_range(0, 4) == 0) ? 7'd64
                                                      : 7'($urandom_range(0, READ_MAX)));
            end else if (pick < 84) begin
                send_fault($urandom);
            end else if (pick < 89) begin
                send_plain(OP_TRAP);
            end else if (pick < 94) begin
                send_plain(($urandom_range(0, 1) == 0) ? OP_RESERVED_A : OP_RESERVED_B);
            end else begin
                send_set($urandom, 3'($urandom_range(0, 7)));
            end
            if ($urandom_range(0, 39) == 0) wait_drained();
        end
    endtask

    task automatic test_log_wrap();
        while (hit_count <= LOG_DEPTH + 4) begin
            if (pick_live_slot() < 0) send_set(pool_addr(), 3'($urandom_range(0, 7)));
            send_fault(watched_page_addr());
            if ($urandom_range(0, 3) == 0) send_plain(OP_TRAP);
        end
        send_read(7'd64);
        send_read(7'($urandom_range(1, READ_MAX - 1)));
        send_plain(OP_CLEAR_ALL);
    endtask

    initial begin
        foreach (page_pool[i]) page_pool[i] = 20'($urandom);
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        test_idle_table();
        test_fill_table();
        test_hit_and_rearm();
        test_output_backpressure();
        test_random_mix();
        test_log_wrap();
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/pwu_pkg.sv
rtl/page_watchpoint_unit.sv
sim/tb_top.sv
